FILE: hdl/length_prefixed_string_deframer_core_defines.svh
// Assertion macros for the length-prefixed string deframer.
// Used by the top level only; depends on a clock named clk and reset rst_n.
`ifndef LENGTH_PREFIXED_STRING_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_STRING_DEFRAMER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LPSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lpsd_pkg.sv
// Shared types and constants of the length-prefixed string deframer.
// No dependencies.
package lpsd_pkg;

  localparam int GROUP_BITS = 7;
  localparam int OUT_LEN_W  = 32;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TOO_LONG = 2'd2
  } lpsd_kind_t;

  typedef struct packed {
    lpsd_kind_t           kind;
    logic [7:0]           data;
    logic                 last;
    logic [OUT_LEN_W-1:0] length;
  } lpsd_result_t;

endpackage

FILE: hdl/lpsd_decode.sv
// Prefix decoder and payload counter of the deframer: holds the stream state
// and forms at most one result per accepted byte. Depends on lpsd_pkg.
module lpsd_decode #(
  parameter int MAX_GROUPS  = 5,
  parameter int LENGTH_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  output logic                 res_valid,
  output lpsd_pkg::lpsd_result_t res
);
  import lpsd_pkg::*;

  localparam int GC_W    = $clog2(MAX_GROUPS + 1);
  localparam int SH_W    = $clog2(GROUP_BITS * MAX_GROUPS);
  localparam int WIDE_W  = LENGTH_BITS + GROUP_BITS * MAX_GROUPS;
  localparam int LEN_EXT = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;

  logic                   in_payload_r, in_payload_nxt;
  logic [LENGTH_BITS-1:0] length_acc_r, length_acc_nxt;
  logic [GC_W-1:0]        group_count_r, group_count_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;

  logic [GC_W-1:0]        gc_eff;
  logic [GC_W-1:0]        gc_inc;
  logic [SH_W-1:0]        shamt;
  logic [WIDE_W-1:0]      group_wide;
  logic [LENGTH_BITS-1:0] acc_or;
  logic [LEN_EXT-1:0]     len_ext;
  logic                   pay_last;

  always_comb begin
    gc_eff     = (group_count_r >= GC_W'(MAX_GROUPS)) ? '0 : group_count_r;
    gc_inc     = gc_eff + GC_W'(1);
    shamt      = SH_W'(gc_eff) * SH_W'(GROUP_BITS);
    group_wide = WIDE_W'(in_byte[6:0]) << shamt;
    acc_or     = length_acc_r | group_wide[LENGTH_BITS-1:0];
    len_ext    = LEN_EXT'(length_acc_r);
    pay_last   = (bytes_left_r <= LENGTH_BITS'(1));
  end

  always_comb begin
    in_payload_nxt  = in_payload_r;
    length_acc_nxt  = length_acc_r;
    group_count_nxt = group_count_r;
    bytes_left_nxt  = bytes_left_r;
    res_valid       = 1'b0;
    res.kind        = KIND_PAYLOAD;
    res.data        = '0;
    res.last        = 1'b0;
    res.length      = '0;
    if (accept) begin
      if (in_payload_r) begin
        res_valid      = 1'b1;
        res.data       = in_byte;
        res.last       = pay_last;
        res.length     = len_ext[OUT_LEN_W-1:0];
        bytes_left_nxt = bytes_left_r - LENGTH_BITS'(1);
        if (pay_last) begin
          in_payload_nxt  = 1'b0;
          length_acc_nxt  = '0;
          group_count_nxt = '0;
          bytes_left_nxt  = '0;
        end
      end else if (in_byte[7]) begin
        if (gc_inc >= GC_W'(MAX_GROUPS)) begin
          // Continuation on the final allowed group: the prefix is malformed.
          res_valid       = 1'b1;
          res.kind        = KIND_TOO_LONG;
          length_acc_nxt  = '0;
          group_count_nxt = '0;
          bytes_left_nxt  = '0;
        end else begin
          length_acc_nxt  = acc_or;
          group_count_nxt = gc_inc;
        end
      end else if (acc_or == '0) begin
        res_valid       = 1'b1;
        res.kind        = KIND_EMPTY;
        res.last        = 1'b1;
        length_acc_nxt  = '0;
        group_count_nxt = '0;
        bytes_left_nxt  = '0;
      end else begin
        in_payload_nxt  = 1'b1;
        length_acc_nxt  = acc_or;
        bytes_left_nxt  = acc_or;
        group_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r  <= 1'b0;
      length_acc_r  <= '0;
      group_count_r <= '0;
      bytes_left_r  <= '0;
    end else begin
      in_payload_r  <= in_payload_nxt;
      length_acc_r  <= length_acc_nxt;
      group_count_r <= group_count_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

endmodule

FILE: hdl/lpsd_outreg.sv
// Result register with a skid stage, so the decoder keeps taking bytes while
// a result waits downstream. Depends on lpsd_pkg.
module lpsd_outreg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lpsd_pkg::lpsd_result_t push_data,
  output logic                  can_accept,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lpsd_pkg::lpsd_result_t out_data
);
  import lpsd_pkg::*;

  logic         out_valid_r;
  lpsd_result_t out_data_r;
  logic         skid_valid_r;
  lpsd_result_t skid_data_r;
  logic         pop;

  assign pop        = out_valid_r & out_ready;
  assign can_accept = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // No push can arrive while the skid stage is full.
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
      out_data_r  <= push_data;
    end else if (push) begin
      skid_data_r  <= push_data;
      skid_valid_r <= 1'b1;
    end
  end

endmodule

FILE: hdl/length_prefixed_string_deframer_core.sv
// Channel | dir | tdata                           | tuser      | tlast
// in_     | in  | [7:0] byte                      | -          | -
// out_    | out | [7:0] byte, [39:8] length       | [1:0] kind | last byte / empty
//
// One byte is taken per cycle while in_tready is high; a result is formed from
// the byte that causes it and is held in the result register or its skid stage.
// Reset (rst_n low, synchronous) returns the block to prefix decoding at once.
// in_tready drops only while both the result register and its skid stage hold
// results that the downstream side has not taken.
// Top level of the deframer; depends on lpsd_pkg, lpsd_decode, lpsd_outreg.
module length_prefixed_string_deframer_core #(
  parameter int MAX_GROUPS  = 5,
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [39:8] out_length
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast
);
  import lpsd_pkg::*;
  `include "length_prefixed_string_deframer_core_defines.svh"

  logic         accept;
  logic         res_valid;
  lpsd_result_t res;
  lpsd_result_t out_res;

  assign accept = in_tvalid & in_tready;

  lpsd_decode #(
    .MAX_GROUPS  (MAX_GROUPS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lpsd_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.length, out_res.data};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  `LPSD_ASSERT_SAME(a_stall_needs_result, !in_tready, out_tvalid,
    "input stalled with no result pending")
  `LPSD_ASSERT_SAME(a_empty_marker_form,
    out_tvalid && (out_tuser == KIND_EMPTY), out_tlast && (out_tdata == '0),
    "empty-string marker malformed")
  `LPSD_ASSERT_SAME(a_error_form,
    out_tvalid && (out_tuser == KIND_TOO_LONG), !out_tlast && (out_tdata == '0),
    "prefix error result malformed")
  `LPSD_ASSERT_NEXT(a_stall_frees_one, !in_tready && out_tready, in_tready,
    "skid stage not drained after a pop")

endmodule
